### rtl/b2da_pkg.sv
// Package for the binary to decimal ASCII converter: widths, the conversion result
// type and the double-dabble step shared by the pipeline stages.
// No dependencies.
`default_nettype none

package b2da_pkg;

  // Field widths.
  localparam int ValueW = 32;
  localparam int CountW = 4;
  localparam int CharW  = 6;
  localparam int DigitW = 4;

  // Digit limit and derived sizes.
  localparam int MaxDigits = 10;
  localparam int NumDigits = MaxDigits;
  localparam int BcdW      = NumDigits * DigitW;
  localparam int WordW     = BcdW + ValueW;
  localparam int PosW      = $clog2(NumDigits);

  // Conversion pipeline: one shift per binary bit, split evenly over the stages.
  localparam int StepsPerStage = 8;
  localparam int NumStages     = ValueW / StepsPerStage;

  localparam logic [CharW-1:0] AsciiZero = CharW'(48);

  // Converted value ready for the digit serializer.
  typedef struct packed {
    logic [NumDigits-1:0][DigitW-1:0] digits;
    logic [PosW-1:0]                  pos;
  } conv_t;

  // One double-dabble step: fix up every BCD digit of five or more, then shift.
  function automatic logic [WordW-1:0] dabble_step(input logic [WordW-1:0] w);
    logic [WordW-1:0] r;
    r = w;
    for (int d = 0; d < NumDigits; d++) begin
      if (r[ValueW + DigitW*d +: DigitW] >= DigitW'(5)) begin
        r[ValueW + DigitW*d +: DigitW] = r[ValueW + DigitW*d +: DigitW] + DigitW'(3);
      end
    end
    return {r[WordW-2:0], 1'b0};
  endfunction

endpackage

`default_nettype wire

### rtl/b2da_in_if.sv
// Input channel of the converter: one binary value and its digit count per beat.
// Depends on b2da_pkg for the field widths.
`default_nettype none

interface b2da_in_if
  import b2da_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic [CountW-1:0] digit_count;

  modport source (output valid, output value, output digit_count, input ready);
  modport sink   (input valid, input value, input digit_count, output ready);
endinterface

`default_nettype wire

### rtl/b2da_out_if.sv
// Output channel of the converter: one ASCII digit per beat, flagged on the last.
// Depends on b2da_pkg for the field widths.
`default_nettype none

interface b2da_out_if
  import b2da_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] digit_char;
  logic             last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

### rtl/b2da_convert.sv
// Pipelined binary to BCD converter with a final stage that resolves the digit count.
// Depends on b2da_pkg and b2da_in_if.
`default_nettype none

module b2da_convert
  import b2da_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b2da_in_if.sink    in_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output conv_t      out_o
);

  logic [NumStages-1:0] vld_q;
  logic [WordW-1:0]     word_q [NumStages];
  logic [CountW-1:0]    cnt_q  [NumStages];
  logic [WordW-1:0]     word_d [NumStages];
  logic [NumStages:0]   adv;

  logic  len_vld_q;
  conv_t len_q;
  conv_t len_d;

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    adv[NumStages] = !len_vld_q || out_ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_i.ready = adv[0];

  // Each stage runs its share of the shift-and-adjust steps.
  always_comb begin
    for (int k = 0; k < NumStages; k++) begin
      if (k == 0) begin
        word_d[k] = {{BcdW{1'b0}}, in_i.value};
      end else begin
        word_d[k] = word_q[k-1];
      end
      for (int s = 0; s < StepsPerStage; s++) begin
        word_d[k] = dabble_step(word_d[k]);
      end
    end
  end

  // Valid bits of the conversion stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= (k == 0) ? in_i.valid : vld_q[k-1];
        end
      end
    end
  end

  // Payload of the conversion stages.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (adv[k]) begin
        word_q[k] <= word_d[k];
        cnt_q[k]  <= (k == 0) ? in_i.digit_count : cnt_q[k-1];
      end
    end
  end

  // Digit count: minimal length when zero is asked for, clamped to the limit.
  always_comb begin
    logic [CountW-1:0] min_len;
    logic [CountW-1:0] cnt;
    len_d.digits = word_q[NumStages-1][WordW-1 -: BcdW];
    min_len = CountW'(1);
    for (int d = 1; d < NumDigits; d++) begin
      if (len_d.digits[d] != '0) begin
        min_len = CountW'(d + 1);
      end
    end
    cnt = cnt_q[NumStages-1];
    if (cnt == '0) begin
      cnt = min_len;
    end
    if (cnt > CountW'(MaxDigits)) begin
      cnt = CountW'(MaxDigits);
    end
    len_d.pos = PosW'(cnt - CountW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q <= 1'b0;
    end else if (adv[NumStages]) begin
      len_vld_q <= vld_q[NumStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NumStages]) begin
      len_q <= len_d;
    end
  end

  assign out_valid_o = len_vld_q;
  assign out_o       = len_q;

endmodule

`default_nettype wire

### rtl/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter: conversion pipeline and digit
// serializer. Depends on b2da_pkg, b2da_in_if, b2da_out_if and b2da_convert.
//
// Each input beat carries a 32-bit unsigned value and a digit count. A count of 1 to 10
// yields exactly that many ASCII digits, most significant first and zero padded (the
// value modulo ten to that power); a count of 0 yields the shortest form, a single '0'
// for zero; counts above 10 are treated as 10. The last digit of each value is flagged.
// A value passes five register stages (four double-dabble stages, eight bits each, and
// one stage that fixes the digit count) and is then loaded into the serializer register.
// The serializer sends one digit per cycle while out_o.ready is high; the pipeline keeps
// taking values meanwhile until its stages are full. A value waiting in the last stage
// is loaded as its predecessor's last digit leaves, so its digits follow without a gap.
`default_nettype none

module binary_to_decimal_ascii
  import b2da_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b2da_in_if.sink    in_i,
  b2da_out_if.source out_o
);

  logic  conv_valid;
  logic  conv_ready;
  conv_t conv;

  logic  ser_vld_q;
  conv_t ser_q;
  logic  ser_last;
  logic  ser_fire;
  logic  ser_load;

  b2da_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_valid_o (conv_valid),
    .out_ready_i (conv_ready),
    .out_o       (conv)
  );

  // The serializer takes a new value when empty or while its last digit leaves.
  assign ser_last   = (ser_q.pos == '0);
  assign ser_fire   = ser_vld_q && out_o.ready;
  assign conv_ready = !ser_vld_q || (out_o.ready && ser_last);
  assign ser_load   = conv_valid && conv_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
    end else if (ser_load) begin
      ser_vld_q <= 1'b1;
    end else if (ser_fire && ser_last) begin
      ser_vld_q <= 1'b0;
    end
  end

  // Digits count down from the most significant position.
  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_q <= conv;
    end else if (ser_fire) begin
      ser_q.pos <= ser_q.pos - PosW'(1);
    end
  end

  assign out_o.valid      = ser_vld_q;
  assign out_o.digit_char = AsciiZero + CharW'(ser_q.digits[ser_q.pos]);
  assign out_o.last_digit = ser_last;

endmodule

`default_nettype wire

### rtl/b2da_check.sv
// Port-level checker for the binary to decimal ASCII converter, bound to its top level.
// Depends on b2da_pkg.
`default_nettype none

module b2da_check
  import b2da_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [CharW-1:0] digit_char_i,
  input wire logic             last_digit_i
);

  logic in_beat;
  logic out_beat;
  logic [3:0]      pending_q;
  logic [PosW-1:0] run_q;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Values accepted whose last digit has not left, and digits sent of the current value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      run_q     <= '0;
    end else begin
      pending_q <= pending_q + 4'(in_beat) - 4'(out_beat && last_digit_i);
      if (out_beat) begin
        run_q <= last_digit_i ? '0 : run_q + PosW'(1);
      end
    end
  end

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (digit_char_i >= AsciiZero) && (digit_char_i <= AsciiZero + CharW'(9)))
    else $error("digit outside the ASCII decimal range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(digit_char_i) && $stable(last_digit_i))
    else $error("stalled output digit changed");

  a_digit_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (run_q == PosW'(MaxDigits - 1)) |-> last_digit_i)
    else $error("value sent more digits than the limit");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pending_q != '0))
    else $error("digit sent without an accepted value");

endmodule

bind binary_to_decimal_ascii b2da_check u_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .digit_char_i (out_o.digit_char),
  .last_digit_i (out_o.last_digit)
);

`default_nettype wire

### tb/binary_to_decimal_ascii_tb.sv
// Testbench for binary_to_decimal_ascii: drives values and digit counts, predicts every
// ASCII digit beat and checks each one as it leaves the block.
// Depends on b2da_pkg, b2da_in_if, b2da_out_if and the binary_to_decimal_ascii RTL.
`default_nettype none

module binary_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b2da_pkg::*;

  // One expected digit beat.
  typedef struct packed {
    logic [CharW-1:0] digit_char;
    logic             last_digit;
  } digit_beat_t;

  logic clk_i;
  logic rst_ni;

  b2da_in_if  in_bus ();
  b2da_out_if out_bus ();

  binary_to_decimal_ascii u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  digit_beat_t pending_digits[$];
  int unsigned n_errors     = 0;
  int unsigned in_idle_pct  = 8;
  int unsigned out_stall_pct = 8;

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Works out the ASCII digits of one value, most significant first, and queues them.
  function automatic void predict_digits(logic [ValueW-1:0] v, logic [CountW-1:0] c);
    int unsigned      n;
    logic [ValueW-1:0] rest;
    logic [DigitW-1:0] dig [MaxDigits];
    digit_beat_t      beat;
    rest = v;
    for (int i = 0; i < MaxDigits; i++) begin
      dig[i] = DigitW'(rest % 10);
      rest   = rest / 10;
    end
    // A count of zero asks for the shortest form.
    if (c == '0) begin
      n    = 1;
      rest = v;
      while (rest >= 10) begin
        rest = rest / 10;
        n++;
      end
    end else begin
      n = c;
    end
    if (n > MaxDigits) n = MaxDigits;
    for (int k = n - 1; k >= 0; k--) begin
      beat.digit_char = AsciiZero + CharW'(dig[k]);
      beat.last_digit = (k == 0);
      pending_digits.push_back(beat);
    end
  endfunction

  // Presents one value, with a random hold-off first, and waits for its beat.
  task automatic send_value(logic [ValueW-1:0] v, logic [CountW-1:0] c);
    @(negedge clk_i);
    while ($urandom_range(99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.value       <= v;
    in_bus.digit_count <= c;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_digits(v, c);
  endtask

  // Ends a burst of input beats.
  task automatic drop_valid();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
  endtask

  // Random value, biased toward small numbers and the edges of each decade.
  function automatic logic [ValueW-1:0] pick_value();
    logic [ValueW-1:0] p;
    int unsigned       sel;
    sel = $urandom_range(9);
    if (sel < 4) return $urandom();
    if (sel < 6) return $urandom_range(999);
    if (sel < 9) begin
      p = 1;
      repeat ($urandom_range(9)) p = p * 10;
      return p + $urandom_range(2) - 1;
    end
    return '1 - $urandom_range(3);
  endfunction

  // Output side: random stalls on ready.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Compares each accepted digit beat with the oldest expectation.
  always @(posedge clk_i) begin
    digit_beat_t exp_beat;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_digits.size() == 0) begin
        $error("digit beat with no value pending: digit_char %0d last_digit %0d",
               out_bus.digit_char, out_bus.last_digit);
        n_errors++;
      end else begin
        exp_beat = pending_digits.pop_front();
        if (out_bus.digit_char !== exp_beat.digit_char) begin
          $error("digit_char: expected %0d, got %0d", exp_beat.digit_char, out_bus.digit_char);
          n_errors++;
        end
        if (out_bus.last_digit !== exp_beat.last_digit) begin
          $error("last_digit: expected %0d, got %0d", exp_beat.last_digit, out_bus.last_digit);
          n_errors++;
        end
      end
    end
  end

  // Extremes of value and count, padding, clamping and full ten-digit values.
  task automatic test_directed_cases();
    send_value(32'd0, 4'd0);
    send_value(32'd0, 4'd1);
    send_value(32'd0, 4'd10);
    send_value(32'd0, 4'd15);
    send_value(32'hFFFF_FFFF, 4'd0);
    send_value(32'hFFFF_FFFF, 4'd10);
    send_value(32'hFFFF_FFFF, 4'd1);
    send_value(32'hFFFF_FFFF, 4'd11);
    send_value(32'hFFFF_FFFF, 4'd15);
    send_value(32'd1234567890, 4'd0);
    send_value(32'd1234567890, 4'd5);
    send_value(32'd1234567890, 4'd9);
    send_value(32'd1000000000, 4'd0);
    send_value(32'd999999999, 4'd0);
    send_value(32'd9, 4'd0);
    send_value(32'd10, 4'd0);
    send_value(32'd7, 4'd3);
    send_value(32'd4000000000, 4'd12);
    send_value(32'h8000_0000, 4'd10);
    send_value(32'd42, 4'd2);
    send_value(32'd42, 4'd1);
    send_value(32'd5, 4'd14);
    drop_valid();
  endtask

  // Random values and counts with random gaps on both sides.
  task automatic test_random_values(int unsigned n_items);
    repeat (n_items) send_value(pick_value(), CountW'($urandom_range(15)));
    drop_valid();
  endtask

  // A long stretch with neither side ever idle.
  task automatic test_back_to_back(int unsigned n_items);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    repeat (n_items) send_value(pick_value(), CountW'($urandom_range(15)));
    drop_valid();
    in_idle_pct   = 8;
    out_stall_pct = 8;
  endtask

  // Lets the block drain completely, then starts again from an empty pipeline.
  task automatic test_drain_restart(int unsigned n_items);
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (n_items) send_value(pick_value(), CountW'($urandom_range(15)));
    drop_valid();
  endtask

  // Run limit.
  initial begin
    #2_000_000;
    $display("binary_to_decimal_ascii_tb NOT OK");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.value       = '0;
    in_bus.digit_count = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_values(140);
    test_back_to_back(80);
    test_drain_restart(80);

    // Wait for the last digits, then keep watching for stray beats.
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("binary_to_decimal_ascii_tb OK");
    end else begin
      $display("binary_to_decimal_ascii_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

### binary_to_decimal_ascii.f
rtl/b2da_pkg.sv
rtl/b2da_in_if.sv
rtl/b2da_out_if.sv
rtl/b2da_convert.sv
rtl/binary_to_decimal_ascii.sv
rtl/b2da_check.sv
tb/binary_to_decimal_ascii_tb.sv
